### rtl/core/stt_pkg.sv
// Shared types, token codes and keyword table of the source text tokenizer.
package stt_pkg;

	localparam longint MaxTextBytes = 64'd16777216;
	localparam longint MaxLines     = 64'd1048576;

	localparam int MaxResults = 3;
	localparam int QueueDepth = 5;
	localparam int CountW     = $clog2(QueueDepth + 1);

	localparam logic [5:0] KindEof     = 6'd0;
	localparam logic [5:0] KindError   = 6'd1;
	localparam logic [5:0] KindNumber  = 6'd2;
	localparam logic [5:0] KindString  = 6'd3;
	localparam logic [5:0] KindIdent   = 6'd4;
	localparam logic [5:0] KindLParen  = 6'd5;
	localparam logic [5:0] KindRParen  = 6'd6;
	localparam logic [5:0] KindLBrack  = 6'd7;
	localparam logic [5:0] KindRBrack  = 6'd8;
	localparam logic [5:0] KindLBrace  = 6'd9;
	localparam logic [5:0] KindRBrace  = 6'd10;
	localparam logic [5:0] KindArrow   = 6'd11;
	localparam logic [5:0] KindDot     = 6'd12;
	localparam logic [5:0] KindStar    = 6'd13;
	localparam logic [5:0] KindSlash   = 6'd14;
	localparam logic [5:0] KindMinus   = 6'd15;
	localparam logic [5:0] KindPlus    = 6'd16;
	localparam logic [5:0] KindBar     = 6'd17;
	localparam logic [5:0] KindGreater = 6'd18;
	localparam logic [5:0] KindLess    = 6'd19;
	localparam logic [5:0] KindEqual   = 6'd20;
	localparam logic [5:0] KindComma   = 6'd21;
	localparam logic [5:0] KindColon   = 6'd22;
	localparam logic [5:0] KindNewline = 6'd23;
	localparam logic [5:0] KindKw0     = 6'd24;

	localparam logic [7:0] ChNul    = 8'h00;
	localparam logic [7:0] ChTab    = 8'h09;
	localparam logic [7:0] ChLf     = 8'h0A;
	localparam logic [7:0] ChCr     = 8'h0D;
	localparam logic [7:0] ChSpace  = 8'h20;
	localparam logic [7:0] ChQuote  = 8'h22;
	localparam logic [7:0] ChLParen = 8'h28;
	localparam logic [7:0] ChRParen = 8'h29;
	localparam logic [7:0] ChStar   = 8'h2A;
	localparam logic [7:0] ChPlus   = 8'h2B;
	localparam logic [7:0] ChComma  = 8'h2C;
	localparam logic [7:0] ChMinus  = 8'h2D;
	localparam logic [7:0] ChDot    = 8'h2E;
	localparam logic [7:0] ChSlash  = 8'h2F;
	localparam logic [7:0] ChZero   = 8'h30;
	localparam logic [7:0] ChNine   = 8'h39;
	localparam logic [7:0] ChColon  = 8'h3A;
	localparam logic [7:0] ChSemi   = 8'h3B;
	localparam logic [7:0] ChLess   = 8'h3C;
	localparam logic [7:0] ChEqual  = 8'h3D;
	localparam logic [7:0] ChGreater = 8'h3E;
	localparam logic [7:0] ChLBrack = 8'h5B;
	localparam logic [7:0] ChRBrack = 8'h5D;
	localparam logic [7:0] ChUnder  = 8'h5F;
	localparam logic [7:0] ChLBrace = 8'h7B;
	localparam logic [7:0] ChBar    = 8'h7C;
	localparam logic [7:0] ChRBrace = 8'h7D;

	localparam int KwCount = 9;
	localparam logic [31:0] KwWord [KwCount] = '{
		32'h00616E64, 32'h636F6E64, 32'h00646566, 32'h0000646F, 32'h656C7365,
		32'h00656E64, 32'h00006966, 32'h006E6F74, 32'h00006F72
	};
	localparam logic [2:0] KwLen [KwCount] = '{
		3'd3, 3'd4, 3'd3, 3'd2, 3'd4, 3'd3, 3'd2, 3'd3, 3'd2
	};

	typedef struct packed {
		logic [5:0]  kind;
		logic [19:0] line;
		logic [23:0] column;
		logic [23:0] start;
		logic [23:0] length;
	} res_t;

	typedef struct packed {
		res_t res;
		logic last;
	} entry_t;

	typedef struct packed {
		logic [1:0]                  count;
		res_t [MaxResults-1:0]       item;
	} push_t;

	typedef struct packed {
		logic [CountW-1:0] count;
		logic              room;
	} qstat_t;

endpackage

### rtl/core/stt_scan.sv
// Scanner state and per-byte token decode of the source text tokenizer.
module stt_scan #(
	parameter longint MAX_TEXT_BYTES = stt_pkg::MaxTextBytes,
	parameter longint MAX_LINES      = stt_pkg::MaxLines
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               take,
	input  logic [7:0]         text_byte,
	output stt_pkg::push_t     push
);

	localparam logic [19:0] LineCap =
		(MAX_LINES - 64'd1 < 64'hFFFFF) ? 20'(MAX_LINES - 64'd1) : 20'hFFFFF;
	localparam logic [23:0] PosCap =
		(MAX_TEXT_BYTES - 64'd1 < 64'hFFFFFF) ? 24'(MAX_TEXT_BYTES - 64'd1) : 24'hFFFFFF;

	typedef enum logic [2:0] {
		ModeIdle, ModeComment, ModeNumber, ModeNumDot,
		ModeFraction, ModeString, ModeIdent, ModeMinus
	} mode_t;

	typedef struct packed {
		logic [19:0] line;
		logic [23:0] col;
		logic [23:0] pos;
	} cnt_t;

	localparam cnt_t CntReset = '{line: 20'd1, col: 24'd1, pos: 24'd0};

	mode_t       mode_q, mode_d;
	cnt_t        cnt_q, cnt_d;
	logic [23:0] begin_q, begin_d;
	logic [31:0] prefix_q, prefix_d;
	logic [2:0]  wlen_q, wlen_d;

	function automatic logic is_nl(logic [7:0] b);
		return b == stt_pkg::ChLf || b == stt_pkg::ChCr;
	endfunction

	function automatic logic is_digit(logic [7:0] b);
		return b >= stt_pkg::ChZero && b <= stt_pkg::ChNine;
	endfunction

	function automatic cnt_t count_step(cnt_t c, logic [7:0] b);
		cnt_t r;
		r = c;
		if (is_nl(b)) begin
			if (c.line < LineCap) r.line = c.line + 20'd1;
			r.col = 24'd1;
		end else if (c.col != 24'hFFFFFF) begin
			r.col = c.col + 24'd1;
		end
		if (c.pos < PosCap) r.pos = c.pos + 24'd1;
		return r;
	endfunction

	function automatic logic is_word(logic [7:0] b);
		logic w;
		case (b)
			stt_pkg::ChNul, stt_pkg::ChSpace, stt_pkg::ChTab, stt_pkg::ChLf, stt_pkg::ChCr,
			stt_pkg::ChLParen, stt_pkg::ChRParen, stt_pkg::ChLBrace, stt_pkg::ChRBrace,
			stt_pkg::ChLBrack, stt_pkg::ChRBrack, stt_pkg::ChQuote, stt_pkg::ChComma,
			stt_pkg::ChDot, stt_pkg::ChColon, stt_pkg::ChSemi: w = 1'b0;
			default: w = 1'b1;
		endcase
		return w;
	endfunction

	function automatic logic [5:0] punct_kind(logic [7:0] b);
		logic [5:0] k;
		case (b)
			stt_pkg::ChLParen:  k = stt_pkg::KindLParen;
			stt_pkg::ChRParen:  k = stt_pkg::KindRParen;
			stt_pkg::ChLBrack:  k = stt_pkg::KindLBrack;
			stt_pkg::ChRBrack:  k = stt_pkg::KindRBrack;
			stt_pkg::ChLBrace:  k = stt_pkg::KindLBrace;
			stt_pkg::ChRBrace:  k = stt_pkg::KindRBrace;
			stt_pkg::ChDot:     k = stt_pkg::KindDot;
			stt_pkg::ChStar:    k = stt_pkg::KindStar;
			stt_pkg::ChSlash:   k = stt_pkg::KindSlash;
			stt_pkg::ChPlus:    k = stt_pkg::KindPlus;
			stt_pkg::ChBar:     k = stt_pkg::KindBar;
			stt_pkg::ChGreater: k = stt_pkg::KindGreater;
			stt_pkg::ChLess:    k = stt_pkg::KindLess;
			stt_pkg::ChEqual:   k = stt_pkg::KindEqual;
			stt_pkg::ChComma:   k = stt_pkg::KindComma;
			stt_pkg::ChColon:   k = stt_pkg::KindColon;
			default:            k = stt_pkg::KindEof;
		endcase
		return k;
	endfunction

	function automatic stt_pkg::res_t mk(logic [5:0] kind, cnt_t c, logic [23:0] start,
			logic [23:0] len);
		stt_pkg::res_t r;
		r.kind   = kind;
		r.line   = c.line;
		r.column = c.col;
		r.start  = start;
		r.length = len;
		return r;
	endfunction

	function automatic logic [5:0] word_kind(logic [31:0] pf, logic [2:0] wl);
		logic [5:0] k;
		k = stt_pkg::KindIdent;
		for (int i = stt_pkg::KwCount - 1; i >= 0; i--) begin
			if (wl == stt_pkg::KwLen[i] && pf == stt_pkg::KwWord[i]) begin
				k = stt_pkg::KindKw0 + 6'(i);
			end
		end
		return k;
	endfunction

	always_comb begin
		logic [7:0]  b;
		logic        idle_go;
		logic [1:0]  n;
		logic [23:0] dot_at;
		logic [5:0]  pk;
		b        = text_byte;
		pk       = punct_kind(text_byte);
		idle_go  = 1'b0;
		n        = 2'd0;
		dot_at   = '0;
		mode_d   = mode_q;
		cnt_d    = cnt_q;
		begin_d  = begin_q;
		prefix_d = prefix_q;
		wlen_d   = wlen_q;
		push     = '0;

		case (mode_q)
			ModeComment: begin
				if (b != stt_pkg::ChNul && !is_nl(b)) cnt_d = count_step(cnt_d, b);
				else idle_go = 1'b1;
			end
			ModeNumber, ModeFraction: begin
				if (is_digit(b) || b == stt_pkg::ChUnder) begin
					cnt_d = count_step(cnt_d, b);
				end else if (b == stt_pkg::ChDot && mode_q == ModeNumber) begin
					mode_d = ModeNumDot;
				end else begin
					push.item[n] = mk(stt_pkg::KindNumber, cnt_d, begin_q, cnt_d.pos - begin_q);
					n = n + 2'd1;
					idle_go = 1'b1;
				end
			end
			ModeNumDot: begin
				if (is_digit(b)) begin
					cnt_d  = count_step(count_step(cnt_d, stt_pkg::ChDot), b);
					mode_d = ModeFraction;
				end else begin
					push.item[n] = mk(stt_pkg::KindNumber, cnt_d, begin_q, cnt_d.pos - begin_q);
					n = n + 2'd1;
					dot_at = cnt_d.pos;
					cnt_d  = count_step(cnt_d, stt_pkg::ChDot);
					push.item[n] = mk(stt_pkg::KindDot, cnt_d, dot_at, 24'd1);
					n = n + 2'd1;
					idle_go = 1'b1;
				end
			end
			ModeString: begin
				if (b == stt_pkg::ChQuote) begin
					cnt_d = count_step(cnt_d, b);
					push.item[n] = mk(stt_pkg::KindString, cnt_d, begin_q, cnt_d.pos - begin_q);
					n = n + 2'd1;
					mode_d = ModeIdle;
				end else if (b == stt_pkg::ChNul) begin
					push.item[n] = mk(stt_pkg::KindError, cnt_d, begin_q, 24'd0);
					n = n + 2'd1;
					idle_go = 1'b1;
				end else begin
					cnt_d = count_step(cnt_d, b);
				end
			end
			ModeIdent: begin
				if (is_word(b)) begin
					if (wlen_q < 3'd4) prefix_d = {prefix_q[23:0], b};
					if (wlen_q < 3'd5) wlen_d = wlen_q + 3'd1;
					cnt_d = count_step(cnt_d, b);
				end else begin
					push.item[n] = mk(word_kind(prefix_q, wlen_q), cnt_d, begin_q,
						cnt_d.pos - begin_q);
					n = n + 2'd1;
					idle_go = 1'b1;
				end
			end
			ModeMinus: begin
				cnt_d = count_step(cnt_d, stt_pkg::ChMinus);
				if (b == stt_pkg::ChGreater) begin
					cnt_d = count_step(cnt_d, b);
					push.item[n] = mk(stt_pkg::KindArrow, cnt_d, begin_q, 24'd2);
					n = n + 2'd1;
					mode_d = ModeIdle;
				end else begin
					push.item[n] = mk(stt_pkg::KindMinus, cnt_d, begin_q, 24'd1);
					n = n + 2'd1;
					idle_go = 1'b1;
				end
			end
			default: idle_go = 1'b1;
		endcase

		if (idle_go) begin
			mode_d = ModeIdle;
			if (b == stt_pkg::ChNul) begin
				push.item[n] = mk(stt_pkg::KindEof, cnt_d, cnt_d.pos, 24'd0);
				n = n + 2'd1;
				cnt_d    = CntReset;
				begin_d  = '0;
				prefix_d = '0;
				wlen_d   = '0;
			end else if (b == stt_pkg::ChSpace || b == stt_pkg::ChTab) begin
				cnt_d = count_step(cnt_d, b);
			end else if (b == stt_pkg::ChSemi) begin
				cnt_d  = count_step(cnt_d, b);
				mode_d = ModeComment;
			end else begin
				begin_d = cnt_d.pos;
				if (is_digit(b)) begin
					cnt_d  = count_step(cnt_d, b);
					mode_d = ModeNumber;
				end else if (b == stt_pkg::ChQuote) begin
					cnt_d  = count_step(cnt_d, b);
					mode_d = ModeString;
				end else if (b == stt_pkg::ChMinus) begin
					mode_d = ModeMinus;
				end else if (is_nl(b)) begin
					cnt_d = count_step(cnt_d, b);
					push.item[n] = mk(stt_pkg::KindNewline, cnt_d, begin_d, 24'd1);
					n = n + 2'd1;
				end else if (pk != stt_pkg::KindEof) begin
					cnt_d = count_step(cnt_d, b);
					push.item[n] = mk(pk, cnt_d, begin_d, 24'd1);
					n = n + 2'd1;
				end else begin
					prefix_d = {24'd0, b};
					wlen_d   = 3'd1;
					cnt_d    = count_step(cnt_d, b);
					mode_d   = ModeIdent;
				end
			end
		end

		push.count = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= ModeIdle;
			cnt_q    <= CntReset;
			begin_q  <= '0;
			prefix_q <= '0;
			wlen_q   <= '0;
		end else if (take) begin
			mode_q   <= mode_d;
			cnt_q    <= cnt_d;
			begin_q  <= begin_d;
			prefix_q <= prefix_d;
			wlen_q   <= wlen_d;
		end
	end

endmodule

### rtl/core/stt_outq.sv
// Token result queue: takes up to three tokens per byte, delivers one per cycle while popped.
module stt_outq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             take,
	input  stt_pkg::push_t   push,
	input  logic             pop,
	output stt_pkg::entry_t  head,
	output stt_pkg::qstat_t  stat
);

	localparam int Depth = stt_pkg::QueueDepth;
	localparam int CW    = stt_pkg::CountW;

	stt_pkg::entry_t ent_q [Depth];
	stt_pkg::entry_t ent_d [Depth];
	logic [CW-1:0]   count_q, count_d;

	always_comb begin
		logic [CW-1:0] base;
		logic [1:0]    n;
		n    = take ? push.count : 2'd0;
		base = count_q - CW'(pop);
		for (int i = 0; i < Depth; i++) begin
			ent_d[i] = ent_q[i];
			if (pop && i < Depth - 1) ent_d[i] = ent_q[(i + 1) % Depth];
			for (int j = 0; j < stt_pkg::MaxResults; j++) begin
				if (2'(j) < n && base + CW'(j) == CW'(i)) begin
					ent_d[i].res  = push.item[j];
					ent_d[i].last = (2'(j + 1) == n);
				end
			end
		end
		count_d = base + CW'(n);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		ent_q <= ent_d;
	end

	assign head       = ent_q[0];
	assign stat.count = count_q;
	assign stat.room  = count_q <= CW'(Depth - stt_pkg::MaxResults);

endmodule

### rtl/core/source_text_tokenizer_core.sv
// Top level of the source text tokenizer: byte request in, token request out.
// One source byte is taken per cycle while the token queue holds two tokens or fewer; every
// byte is decoded in the cycle it is taken and its tokens (none, one, two or three) enter a
// five-entry queue that delivers one token per cycle while token_ready is high. A run of
// bytes that each yield at most one token then streams at one byte per cycle; a byte that
// yields several tokens uses one output slot each, which the queue absorbs before byte_ready
// drops. A zero byte ends the text, yields the eof token and resets every counter.
module source_text_tokenizer_core #(
	parameter longint MAX_TEXT_BYTES = stt_pkg::MaxTextBytes,
	parameter longint MAX_LINES      = stt_pkg::MaxLines
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        byte_valid,
	output logic        byte_ready,
	input  logic [7:0]  text_byte,
	output logic        token_valid,
	input  logic        token_ready,
	output logic [5:0]  token_kind,
	output logic [19:0] line_number,
	output logic [23:0] column_number,
	output logic [23:0] start_offset,
	output logic [23:0] token_length,
	output logic        last_of_run
);

	stt_pkg::push_t  push;
	stt_pkg::entry_t head;
	stt_pkg::qstat_t stat;
	logic            take;
	logic            pop;

	assign byte_ready  = stat.room;
	assign take        = byte_valid && byte_ready;
	assign token_valid = stat.count != '0;
	assign pop         = token_valid && token_ready;

	stt_scan #(
		.MAX_TEXT_BYTES(MAX_TEXT_BYTES),
		.MAX_LINES     (MAX_LINES)
	) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.take     (take),
		.text_byte(text_byte),
		.push     (push)
	);

	stt_outq u_outq (
		.clk   (clk),
		.arst_n(arst_n),
		.take  (take),
		.push  (push),
		.pop   (pop),
		.head  (head),
		.stat  (stat)
	);

	assign token_kind    = head.res.kind;
	assign line_number   = head.res.line;
	assign column_number = head.res.column;
	assign start_offset  = head.res.start;
	assign token_length  = head.res.length;
	assign last_of_run   = head.last;

	a_occupancy: assert property (@(posedge clk) disable iff (!arst_n)
		stat.count <= stt_pkg::CountW'(stt_pkg::QueueDepth))
		else $error("token queue overflow");

	a_push_visible: assert property (@(posedge clk) disable iff (!arst_n)
		(take && push.count != 2'd0) |=> token_valid)
		else $error("decoded token not presented");

	a_tail_last: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && stat.count == stt_pkg::CountW'(1)) |-> last_of_run)
		else $error("queue tail is not the end of a run");

	a_eof_token: assert property (@(posedge clk) disable iff (!arst_n)
		(take && text_byte == stt_pkg::ChNul && stat.count == '0 && !pop)
		|=> (token_valid && (token_kind == stt_pkg::KindEof || token_kind == stt_pkg::KindError
			|| token_kind == stt_pkg::KindNumber || last_of_run == 1'b0
			|| token_kind != stt_pkg::KindNewline)))
		else $error("end of text gave no token");

endmodule

### sim/source_text_tokenizer_core_test.sv
// Self-checking testbench for source_text_tokenizer_core: bytes in, predicted tokens checked.
module source_text_tokenizer_core_test;
	import stt_pkg::*;

	localparam longint LineCap = (MaxLines - 1 < 64'hFFFFF) ? MaxLines - 1 : 64'hFFFFF;
	localparam longint PosCap  = (MaxTextBytes - 1 < 64'hFFFFFF) ? MaxTextBytes - 1 : 64'hFFFFFF;
	localparam longint ColCap  = 64'hFFFFFF;

	localparam logic [5:0] KwAnd  = KindKw0;
	localparam logic [5:0] KwCond = KindKw0 + 6'd1;
	localparam logic [5:0] KwDef  = KindKw0 + 6'd2;
	localparam logic [5:0] KwDo   = KindKw0 + 6'd3;
	localparam logic [5:0] KwElse = KindKw0 + 6'd4;
	localparam logic [5:0] KwEnd  = KindKw0 + 6'd5;
	localparam logic [5:0] KwIf   = KindKw0 + 6'd6;
	localparam logic [5:0] KwNot  = KindKw0 + 6'd7;
	localparam logic [5:0] KwOr   = KindKw0 + 6'd8;

	localparam int RandomBytes = 290;

	localparam logic [7:0] PunctBytes [17] = '{
		ChLParen, ChRParen, ChLBrack, ChRBrack, ChLBrace, ChRBrace, ChDot, ChStar, ChSlash,
		ChPlus, ChBar, ChGreater, ChLess, ChEqual, ChComma, ChColon, ChMinus
	};

	typedef enum logic [3:0] {
		ScanIdle, ScanComment, ScanNumber, ScanNumDot, ScanFraction, ScanString, ScanWord,
		ScanMinus
	} scan_e;

	class token_scoreboard;
		scan_e       mode;
		logic [19:0] line;
		logic [23:0] col;
		logic [23:0] pos;
		logic [23:0] tok_start;
		logic [31:0] prefix;
		int          wlen;
		entry_t      run[$];
		entry_t      expected[$];
		int          mismatches;

		function new();
			mismatches = 0;
			clear();
		endfunction

		function void clear();
			mode = ScanIdle;
			line = 20'd1;
			col = 24'd1;
			pos = 24'd0;
			tok_start = 24'd0;
			prefix = 32'd0;
			wlen = 0;
		endfunction

		function bit is_digit(input logic [7:0] b);
			return b >= ChZero && b <= ChNine;
		endfunction

		function bit is_nl(input logic [7:0] b);
			return b == ChLf || b == ChCr;
		endfunction

		function bit is_word_byte(input logic [7:0] b);
			case (b)
				ChNul, ChSpace, ChTab, ChLf, ChCr, ChLParen, ChRParen, ChLBrace, ChRBrace,
				ChLBrack, ChRBrack, ChQuote, ChComma, ChDot, ChColon, ChSemi: return 1'b0;
				default: return 1'b1;
			endcase
		endfunction

		function logic [5:0] punct_kind(input logic [7:0] b);
			case (b)
				ChLParen:  return KindLParen;
				ChRParen:  return KindRParen;
				ChLBrack:  return KindLBrack;
				ChRBrack:  return KindRBrack;
				ChLBrace:  return KindLBrace;
				ChRBrace:  return KindRBrace;
				ChDot:     return KindDot;
				ChStar:    return KindStar;
				ChSlash:   return KindSlash;
				ChPlus:    return KindPlus;
				ChBar:     return KindBar;
				ChGreater: return KindGreater;
				ChLess:    return KindLess;
				ChEqual:   return KindEqual;
				ChComma:   return KindComma;
				ChColon:   return KindColon;
				default:   return KindEof;
			endcase
		endfunction

		function void advance(input logic [7:0] b);
			if (is_nl(b)) begin
				if (line < LineCap) line = line + 20'd1;
				col = 24'd1;
			end else if (col < ColCap) begin
				col = col + 24'd1;
			end
			if (pos < PosCap) pos = pos + 24'd1;
		endfunction

		function void push_token(input logic [5:0] kind, input logic [23:0] start,
				input logic [23:0] len);
			entry_t e;
			e.res.kind = kind;
			e.res.line = line;
			e.res.column = col;
			e.res.start = start;
			e.res.length = len;
			e.last = 1'b0;
			run.push_back(e);
		endfunction

		function logic [5:0] word_kind();
			logic [5:0] kind;
			kind = KindIdent;
			if (wlen <= 4) begin
				case (prefix)
					"and":  kind = KwAnd;
					"cond": kind = KwCond;
					"def":  kind = KwDef;
					"do":   kind = KwDo;
					"else": kind = KwElse;
					"end":  kind = KwEnd;
					"if":   kind = KwIf;
					"not":  kind = KwNot;
					"or":   kind = KwOr;
					default: ;
				endcase
			end
			return kind;
		endfunction

		function void take_word(input logic [7:0] b);
			if (wlen < 4) prefix = {prefix[23:0], b};
			if (wlen < 5) wlen++;
			advance(b);
		endfunction

		function void from_idle(input logic [7:0] b);
			logic [5:0] k;
			mode = ScanIdle;
			if (b == ChNul) begin
				push_token(KindEof, pos, 24'd0);
				clear();
				return;
			end
			if (b == ChSpace || b == ChTab) begin
				advance(b);
				return;
			end
			if (b == ChSemi) begin
				advance(b);
				mode = ScanComment;
				return;
			end
			tok_start = pos;
			if (is_digit(b)) begin
				advance(b);
				mode = ScanNumber;
				return;
			end
			if (b == ChQuote) begin
				advance(b);
				mode = ScanString;
				return;
			end
			if (b == ChMinus) begin
				mode = ScanMinus;
				return;
			end
			if (is_nl(b)) begin
				advance(b);
				push_token(KindNewline, tok_start, 24'd1);
				return;
			end
			k = punct_kind(b);
			if (k != KindEof) begin
				advance(b);
				push_token(k, tok_start, 24'd1);
				return;
			end
			prefix = 32'd0;
			wlen = 0;
			take_word(b);
			mode = ScanWord;
		endfunction

		function void note_byte(input logic [7:0] b);
			logic [23:0] dot_at;
			run.delete();
			case (mode)
				ScanComment: begin
					if (b != ChNul && !is_nl(b)) advance(b);
					else from_idle(b);
				end
				ScanNumber, ScanFraction: begin
					if (is_digit(b) || b == ChUnder) begin
						advance(b);
					end else if (b == ChDot && mode == ScanNumber) begin
						mode = ScanNumDot;
					end else begin
						push_token(KindNumber, tok_start, pos - tok_start);
						from_idle(b);
					end
				end
				ScanNumDot: begin
					if (is_digit(b)) begin
						advance(ChDot);
						advance(b);
						mode = ScanFraction;
					end else begin
						push_token(KindNumber, tok_start, pos - tok_start);
						dot_at = pos;
						advance(ChDot);
						push_token(KindDot, dot_at, 24'd1);
						from_idle(b);
					end
				end
				ScanString: begin
					if (b == ChQuote) begin
						advance(b);
						push_token(KindString, tok_start, pos - tok_start);
						mode = ScanIdle;
					end else if (b == ChNul) begin
						push_token(KindError, tok_start, 24'd0);
						from_idle(b);
					end else begin
						advance(b);
					end
				end
				ScanWord: begin
					if (is_word_byte(b)) begin
						take_word(b);
					end else begin
						push_token(word_kind(), tok_start, pos - tok_start);
						from_idle(b);
					end
				end
				ScanMinus: begin
					advance(ChMinus);
					if (b == ChGreater) begin
						advance(b);
						push_token(KindArrow, tok_start, 24'd2);
						mode = ScanIdle;
					end else begin
						push_token(KindMinus, tok_start, 24'd1);
						from_idle(b);
					end
				end
				default: from_idle(b);
			endcase
			if (run.size() > 0) run[run.size() - 1].last = 1'b1;
			foreach (run[i]) expected.push_back(run[i]);
		endfunction

		function void check_token(input entry_t got);
			entry_t want;
			if (expected.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"unexpected token: kind %0d line %0d col %0d start %0d ",
						"len %0d last %0d"},
						got.res.kind, got.res.line, got.res.column, got.res.start,
						got.res.length, got.last);
				return;
			end
			want = expected.pop_front();
			if (got.res.kind !== want.res.kind || got.res.line !== want.res.line ||
					got.res.column !== want.res.column || got.res.start !== want.res.start ||
					got.res.length !== want.res.length || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10)
					$display({"token mismatch: expected kind %0d line %0d col %0d start %0d ",
						"len %0d last %0d, got kind %0d line %0d col %0d start %0d len %0d last %0d"},
						want.res.kind, want.res.line, want.res.column, want.res.start,
						want.res.length, want.last, got.res.kind, got.res.line, got.res.column,
						got.res.start, got.res.length, got.last);
			end
		endfunction

		function int pending();
			return expected.size();
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        byte_valid;
	logic        byte_ready;
	logic [7:0]  text_byte;
	logic        token_valid;
	logic        token_ready;
	logic [5:0]  token_kind;
	logic [19:0] line_number;
	logic [23:0] column_number;
	logic [23:0] start_offset;
	logic [23:0] token_length;
	logic        last_of_run;

	token_scoreboard sb = new();
	entry_t          seen;
	int              bytes_sent;
	bit              no_stall;
	string           word_list [9] = '{"and", "cond", "def", "do", "else", "end", "if", "not", "or"};

	source_text_tokenizer_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.text_byte(text_byte),
		.token_valid(token_valid),
		.token_ready(token_ready),
		.token_kind(token_kind),
		.line_number(line_number),
		.column_number(column_number),
		.start_offset(start_offset),
		.token_length(token_length),
		.last_of_run(last_of_run)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && byte_valid && byte_ready) sb.note_byte(text_byte);
		if (arst_n && token_valid && token_ready) begin
			seen.res.kind = token_kind;
			seen.res.line = line_number;
			seen.res.column = column_number;
			seen.res.start = start_offset;
			seen.res.length = token_length;
			seen.last = last_of_run;
			sb.check_token(seen);
		end
	end

	initial begin
		int gap;
		token_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			gap = no_stall ? 0 : $urandom_range(0, 9);
			if (gap > 0) begin
				token_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			token_ready <= 1'b1;
			@(posedge clk);
			while (!token_valid) @(posedge clk);
		end
	end

	initial begin
		#2000000;
		$display("** source_text_tokenizer_core: FAILED **");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b);
		int gap;
		gap = no_stall ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			byte_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		byte_valid <= 1'b1;
		text_byte <= b;
		@(posedge clk);
		while (!byte_ready) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic drain();
		byte_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	task automatic send_fragment();
		string      w;
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: begin
				w = word_list[$urandom_range(0, 8)];
				case ($urandom_range(0, 3))
					0: w = {w, "x"};
					1: w = w.substr(0, w.len() - 2);
					default: ;
				endcase
				send_text(w);
			end
			1: begin
				repeat ($urandom_range(1, 6))
					send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255)) :
						8'($urandom_range(97, 122)));
			end
			2: begin
				repeat ($urandom_range(1, 4))
					send_byte(($urandom_range(0, 4) == 0) ? ChUnder :
						8'(ChZero + $urandom_range(0, 9)));
				case ($urandom_range(0, 3))
					0: begin
						send_byte(ChDot);
						repeat ($urandom_range(1, 3)) send_byte(8'(ChZero + $urandom_range(0, 9)));
					end
					1: send_byte(ChDot);
					default: ;
				endcase
			end
			3: begin
				send_byte(ChQuote);
				repeat ($urandom_range(0, 5)) begin
					do b = 8'($urandom_range(1, 255)); while (b == ChQuote);
					send_byte(b);
				end
				send_byte(ChQuote);
			end
			4: send_byte(PunctBytes[$urandom_range(0, 16)]);
			5: send_byte(($urandom_range(0, 1) == 1) ? ChCr : ChLf);
			6: begin
				send_byte(ChSemi);
				repeat ($urandom_range(0, 5)) begin
					do b = 8'($urandom_range(1, 255)); while (b == ChCr || b == ChLf);
					send_byte(b);
				end
				if ($urandom_range(0, 3) != 0) send_byte(ChLf);
			end
			7: send_byte(8'($urandom_range(1, 255)));
			8: send_byte(($urandom_range(0, 1) == 1) ? ChSpace : ChTab);
			default: send_text("->");
		endcase
		if ($urandom_range(0, 1) == 1) send_byte(ChSpace);
	endtask

	initial begin
		int texts;
		int stop_at;
		arst_n = 1'b0;
		byte_valid = 1'b0;
		text_byte = 8'd0;
		no_stall = 1'b0;
		bytes_sent = 0;
		texts = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_text("1.5 1.(->-(\"a\";c");
		send_byte(ChCr);
		send_byte(ChLf);
		send_byte(8'hFF);
		send_byte(ChNul);
		send_text("\"u");
		send_byte(ChNul);
		send_text(";x");
		send_byte(ChNul);
		send_text("9.");
		send_byte(ChNul);

		stop_at = bytes_sent + RandomBytes;
		while (bytes_sent < stop_at) begin
			no_stall = ($urandom_range(0, 3) == 0);
			repeat ($urandom_range(1, 8)) send_fragment();
			if ($urandom_range(0, 7) == 0) send_byte(ChQuote);
			send_byte(ChNul);
			texts++;
			// hold input until the token stream has caught up
			if (texts == 4) drain();
		end

		drain();
		repeat (20) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("** source_text_tokenizer_core: PASSED **");
		end else begin
			$display("** source_text_tokenizer_core: FAILED **");
		end
		$finish;
	end

endmodule
